>>> design/acfd_pkg.sv
// Shared types and constants for the ADC channel frame deframer.
// No dependencies; used by acfd_step and adc_channel_frame_deframer.
package acfd_pkg;

  localparam logic [4:0] MAX_CHANNELS = 5'd16;
  localparam logic [7:0] HEAD_MASK    = 8'hE0;
  localparam logic [7:0] HEAD_MARK    = 8'hA0;
  localparam int unsigned BUSY_BIT    = 4;
  localparam int unsigned DATA_FLAG   = 7;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    EV_PROGRESS = 3'd0,
    EV_ACCEPTED = 3'd1,
    EV_INVALID  = 3'd2,
    EV_ORDER    = 3'd3,
    EV_SKIPPED  = 3'd4
  } event_e;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] lat_channel;
    logic       lat_busy;
    logic [6:0] high_part;
    logic [3:0] exp_channel;
    logic       last_known;
    logic       last_busy;
  } state_t;

  typedef struct packed {
    event_e     event_res;
    logic [3:0] channel;
    logic [9:0] sample_value;
    logic       set_complete;
    logic       adc_busy;
    logic       busy_changed;
  } result_t;

endpackage

>>> design/acfd_step.sv
// Next-state and result logic for one received byte.
// Depends on acfd_pkg.
module acfd_step (
  input  acfd_pkg::state_t  state_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [4:0]        count_i,
  output acfd_pkg::state_t  state_o,
  output acfd_pkg::result_t result_o
);

  logic       is_head;
  logic [4:0] exp_next;

  assign is_head  = (rx_byte_i & acfd_pkg::HEAD_MASK) == acfd_pkg::HEAD_MARK;
  assign exp_next = {1'b0, state_i.exp_channel} + 5'd1;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.event_res = acfd_pkg::EV_PROGRESS;
    case (state_i.phase)
      acfd_pkg::PH_HIGH, acfd_pkg::PH_LOW: begin
        if (rx_byte_i[acfd_pkg::DATA_FLAG]) begin
          // bad data byte, retried as a head
          result_o.event_res = acfd_pkg::EV_INVALID;
          result_o.channel   = state_i.lat_channel;
          if (is_head) begin
            state_o.lat_busy    = rx_byte_i[acfd_pkg::BUSY_BIT];
            state_o.lat_channel = rx_byte_i[3:0];
            state_o.phase       = acfd_pkg::PH_HIGH;
          end else begin
            state_o.phase = acfd_pkg::PH_HUNT;
          end
        end else if (state_i.phase == acfd_pkg::PH_HIGH) begin
          state_o.high_part = rx_byte_i[6:0];
          state_o.phase     = acfd_pkg::PH_LOW;
        end else begin
          state_o.phase   = acfd_pkg::PH_HUNT;
          result_o.channel = state_i.lat_channel;
          if (state_i.high_part[3:0] != rx_byte_i[6:3]) begin
            result_o.event_res = acfd_pkg::EV_INVALID;
          end else if (state_i.lat_channel != state_i.exp_channel) begin
            result_o.event_res = acfd_pkg::EV_ORDER;
          end else begin
            result_o.event_res    = acfd_pkg::EV_ACCEPTED;
            result_o.sample_value = {state_i.high_part, 3'b000} | {3'b000, rx_byte_i[6:0]};
            if (exp_next >= count_i) begin
              result_o.set_complete = 1'b1;
              state_o.exp_channel   = 4'd0;
            end else begin
              state_o.exp_channel = exp_next[3:0];
            end
            result_o.adc_busy = state_i.lat_busy;
            if (!state_i.last_known || (state_i.last_busy != state_i.lat_busy)) begin
              result_o.busy_changed = 1'b1;
              state_o.last_known    = 1'b1;
              state_o.last_busy     = state_i.lat_busy;
            end
          end
        end
      end
      default: begin
        if (is_head) begin
          state_o.lat_busy    = rx_byte_i[acfd_pkg::BUSY_BIT];
          state_o.lat_channel = rx_byte_i[3:0];
          state_o.phase       = acfd_pkg::PH_HIGH;
        end else begin
          state_o.phase      = acfd_pkg::PH_HUNT;
          result_o.event_res = acfd_pkg::EV_SKIPPED;
        end
      end
    endcase
  end

endmodule

>>> design/adc_channel_frame_deframer.sv
// Top level of the ADC channel frame deframer: input register, parser state,
// result register. Depends on acfd_pkg and acfd_step.
//
// One result per request. A request passes through the input register, then the
// result register, before its result is valid; the block accepts a request
// every cycle as long as results are taken, since the parser state updates in
// one pass of acfd_step. Channel count writes are clamped to 1..16.
module adc_channel_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] event_res_o,
  output logic [3:0] channel_o,
  output logic [9:0] sample_value_o,
  output logic       set_complete_o,
  output logic       adc_busy_o,
  output logic       busy_changed_o
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  acfd_pkg::result_t res_q;
  acfd_pkg::result_t res_d;
  acfd_pkg::state_t  state_q;
  acfd_pkg::state_t  state_d;
  logic [4:0]        count_q;
  logic [4:0]        count_d;
  logic              advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    if (cfg_wdata_i == 5'd0) begin
      count_d = 5'd1;
    end else if (cfg_wdata_i > acfd_pkg::MAX_CHANNELS) begin
      count_d = acfd_pkg::MAX_CHANNELS;
    end else begin
      count_d = cfg_wdata_i;
    end
  end

  acfd_step u_step (
    .state_i   (state_q),
    .rx_byte_i (in_byte_q),
    .count_i   (count_q),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= acfd_pkg::MAX_CHANNELS;
      state_q     <= '{phase: acfd_pkg::PH_HUNT, default: '0};
    end else begin
      if (cfg_we_i) begin
        count_q <= count_d;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = res_q.event_res;
  assign channel_o      = res_q.channel;
  assign sample_value_o = res_q.sample_value;
  assign set_complete_o = res_q.set_complete;
  assign adc_busy_o     = res_q.adc_busy;
  assign busy_changed_o = res_q.busy_changed;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for adc_channel_frame_deframer: drives serial bytes,
// predicts each parser event in a small tracker class and checks every result.
// Depends on acfd_pkg and the design files.
module testbench;

  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned PHASES = 10;

  class frame_tracker;
    acfd_pkg::phase_e  phase;
    logic [3:0]        lat_ch;
    logic              lat_busy;
    logic [6:0]        high_part;
    logic [3:0]        exp_ch;
    logic              busy_known;
    logic              last_busy;
    logic [4:0]        count_reg;
    acfd_pkg::result_t due[$];
    int                errors;
    int                checked;
    int                sets_done;
    int                busy_flips;
    int                tally[5];

    function new();
      phase      = acfd_pkg::PH_HUNT;
      lat_ch     = '0;
      lat_busy   = 1'b0;
      high_part  = '0;
      exp_ch     = '0;
      busy_known = 1'b0;
      last_busy  = 1'b0;
      count_reg  = acfd_pkg::MAX_CHANNELS;
      errors     = 0;
      checked    = 0;
      sets_done  = 0;
      busy_flips = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    function void write_count(logic [4:0] value);
      count_reg = value;
    endfunction

    function bit latch_head(logic [7:0] b);
      if ((b & acfd_pkg::HEAD_MASK) == acfd_pkg::HEAD_MARK) begin
        lat_busy = b[acfd_pkg::BUSY_BIT];
        lat_ch   = b[3:0];
        phase    = acfd_pkg::PH_HIGH;
        return 1'b1;
      end
      phase = acfd_pkg::PH_HUNT;
      return 1'b0;
    endfunction

    // Predict the event for one accepted request and queue it.
    function void parse_byte(logic [7:0] b);
      acfd_pkg::result_t r;
      logic [4:0]        n;
      r = '0;
      n = count_reg;
      if (n == 5'd0) n = 5'd1;
      if (n > acfd_pkg::MAX_CHANNELS) n = acfd_pkg::MAX_CHANNELS;
      if (phase == acfd_pkg::PH_HIGH || phase == acfd_pkg::PH_LOW) begin
        if (b[acfd_pkg::DATA_FLAG]) begin
          r.event_res = acfd_pkg::EV_INVALID;
          r.channel   = lat_ch;
          void'(latch_head(b));
        end else if (phase == acfd_pkg::PH_HIGH) begin
          high_part = b[6:0];
          phase     = acfd_pkg::PH_LOW;
        end else begin
          phase     = acfd_pkg::PH_HUNT;
          r.channel = lat_ch;
          if (high_part[3:0] != b[6:3]) begin
            r.event_res = acfd_pkg::EV_INVALID;
          end else if (lat_ch != exp_ch) begin
            r.event_res = acfd_pkg::EV_ORDER;
          end else begin
            r.event_res    = acfd_pkg::EV_ACCEPTED;
            r.sample_value = {high_part, 3'b000} | {3'b000, b[6:0]};
            if ({1'b0, exp_ch} + 5'd1 >= n) begin
              r.set_complete = 1'b1;
              exp_ch = '0;
              sets_done++;
            end else begin
              exp_ch = exp_ch + 4'd1;
            end
            r.adc_busy = lat_busy;
            if (!busy_known || last_busy != lat_busy) begin
              r.busy_changed = 1'b1;
              busy_known = 1'b1;
              last_busy  = lat_busy;
              busy_flips++;
            end
          end
        end
      end else if (!latch_head(b)) begin
        r.event_res = acfd_pkg::EV_SKIPPED;
      end
      tally[int'(r.event_res)]++;
      due.push_back(r);
    endfunction

    function bit same(string what, logic [9:0] want, logic [9:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void match_result(acfd_pkg::result_t got);
      acfd_pkg::result_t want;
      bit                ok;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, event %0d", $time, got.event_res);
        return;
      end
      want = due.pop_front();
      ok = 1'b1;
      ok &= same("event_res", 10'(want.event_res), 10'(got.event_res));
      ok &= same("channel", 10'(want.channel), 10'(got.channel));
      ok &= same("sample_value", want.sample_value, got.sample_value);
      ok &= same("set_complete", 10'(want.set_complete), 10'(got.set_complete));
      ok &= same("adc_busy", 10'(want.adc_busy), 10'(got.adc_busy));
      ok &= same("busy_changed", 10'(want.busy_changed), 10'(got.busy_changed));
      if (!ok) errors++;
      checked++;
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni         = 1'b0;
  logic       cfg_we_i       = 1'b0;
  logic [4:0] cfg_wdata_i    = '0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i      = '0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [2:0] event_res_o;
  logic [3:0] channel_o;
  logic [9:0] sample_value_o;
  logic       set_complete_o;
  logic       adc_busy_o;
  logic       busy_changed_o;

  frame_tracker tracker = new();
  int gap_pct   = 0;
  int stall_pct = 0;
  int bytes_sent = 0;

  adc_channel_frame_deframer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .channel_o      (channel_o),
    .sample_value_o (sample_value_o),
    .set_complete_o (set_complete_o),
    .adc_busy_o     (adc_busy_o),
    .busy_changed_o (busy_changed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("%0t: timeout, %0d results still pending", $time, tracker.due.size());
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin : monitor
    acfd_pkg::result_t got;
    if (rst_ni) begin
      if (cfg_we_i) tracker.write_count(cfg_wdata_i);
      if (out_valid_o && out_ready_i) begin
        got.event_res    = acfd_pkg::event_e'(event_res_o);
        got.channel      = channel_o;
        got.sample_value = sample_value_o;
        got.set_complete = set_complete_o;
        got.adc_busy     = adc_busy_o;
        got.busy_changed = busy_changed_o;
        tracker.match_result(got);
      end
      if (in_valid_i && in_ready_o) tracker.parse_byte(rx_byte_i);
    end
  end

  initial begin : result_sink
    int stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0 && stall_pct > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall = $urandom_range(1, 11) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with valid possibly still high.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    bytes_sent++;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'($urandom);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_count(input logic [4:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed packets in channel order, plus bad checks, broken packets, noise.
  task automatic send_packet();
    int         kind;
    logic [3:0] ch;
    logic       busy;
    logic [9:0] v;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] bad;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      send_byte(8'($urandom));
      return;
    end
    ch   = ($urandom_range(0, 9) == 0) ? 4'($urandom) : tracker.exp_ch;
    busy = ($urandom_range(0, 3) == 0) ? ~tracker.last_busy : tracker.last_busy;
    v    = 10'($urandom);
    hi   = {1'b0, v[9:3]};
    lo   = {1'b0, v[6:0]};
    if (kind >= 80) lo = lo ^ (8'h08 << $urandom_range(0, 3));
    send_byte({3'b101, busy, ch});
    if (kind >= 70 && kind < 80) begin
      bad = ($urandom_range(0, 1) == 1) ? {3'b101, 5'($urandom)} : 8'($urandom_range(128, 255));
      if ($urandom_range(0, 1) == 1) begin
        send_byte(bad);
      end else begin
        send_byte(hi);
        send_byte(bad);
      end
      return;
    end
    send_byte(hi);
    send_byte(lo);
  endtask

  initial begin : stimulus
    logic [7:0] directed[$];
    logic [4:0] counts[PHASES];
    int         gaps[PHASES];
    int         stalls[PHASES];
    int         start;
    directed = '{8'h00, 8'hFF, 8'h7F,
                 8'hA0, 8'h00, 8'h00,
                 8'hB1, 8'h7F, 8'h7F,
                 8'hA2, 8'hA2, 8'h05, 8'h28,
                 8'hA3, 8'h01, 8'h00,
                 8'hBF, 8'h00, 8'h00,
                 8'hA3, 8'h00, 8'hC0,
                 8'hA3, 8'h55, 8'h2A};
    counts = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd16, 5'd7, 5'd2, 5'd12, 5'd5, 5'd16};
    gaps   = '{20, 10, 30, 0, 15, 25, 10, 20, 15, 0};
    stalls = '{15, 25, 10, 0, 30, 10, 20, 15, 20, 0};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_count(5'd16);
    gap_pct   = 20;
    stall_pct = 20;
    foreach (directed[i]) send_byte(directed[i]);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_count(counts[p]);
      gap_pct   = gaps[p];
      stall_pct = stalls[p];
      start = bytes_sent;
      while (bytes_sent - start < 165) send_packet();
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes over %0d channel counts; %0d results checked, %0d mismatched.",
             bytes_sent, PHASES + 1, tracker.checked, tracker.errors);
    $display("Values %0d, sets %0d, busy flips %0d, invalid %0d, out of order %0d, skipped %0d.",
             tracker.tally[acfd_pkg::EV_ACCEPTED], tracker.sets_done, tracker.busy_flips,
             tracker.tally[acfd_pkg::EV_INVALID], tracker.tally[acfd_pkg::EV_ORDER],
             tracker.tally[acfd_pkg::EV_SKIPPED]);
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
